FILE: sv/overlap_pair_sort_dedup_macros.svh
// ---------------------------------------------------------------------------
// overlap_pair_sort_dedup_macros.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef OVERLAP_PAIR_SORT_DEDUP_MACROS_SVH
`define OVERLAP_PAIR_SORT_DEDUP_MACROS_SVH

// same-cycle implication, disabled during reset
`define OPSD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("opsd assertion failed");

// next-cycle implication, disabled during reset
`define OPSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("opsd assertion failed");

`endif

FILE: sv/opsd_pkg.sv
// ---------------------------------------------------------------------------
// opsd_pkg
// Types and constants of the overlap pair sort and dedup block.
// ---------------------------------------------------------------------------
package opsd_pkg;

	localparam int MAX_PAIRS = 64;
	localparam int ID_BITS   = 16;
	localparam int ID_W      = 16;
	localparam int KEY_W     = 2 * ID_BITS;
	localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
	localparam int ADDR_W    = $clog2(MAX_PAIRS);

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FRD,
		ST_FOUT,
		ST_FEMPTY
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0] pair_low;
		logic [ID_W-1:0] pair_high;
		logic            is_empty;
		logic            overflowed;
		logic            last;
	} res_t;

	typedef struct packed {
		logic load;
		res_t res;
	} out_req_t;

endpackage

FILE: sv/opsd_ram.sv
// ---------------------------------------------------------------------------
// opsd_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
module opsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/opsd_ctrl.sv
// ---------------------------------------------------------------------------
// opsd_ctrl
// Sequencer: sorted, deduplicated insertion into the pair RAM on add words,
// in-order readout of the RAM on finish words.
// ---------------------------------------------------------------------------
module opsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_kind,
	input  logic [15:0]       in_first,
	input  logic [15:0]       in_second,
	input  logic              out_free,
	output opsd_pkg::out_req_t out_req
);
	import opsd_pkg::*;

	state_t state_q, state_d;
	cnt_t   cnt_q;
	cnt_t   ucnt_q;
	logic   ovf_q;
	addr_t  k_q;
	logic   ins_q;
	key_t   key_q;
	key_t   carry_q;

	logic   acc;
	id_t    id_a, id_b;
	key_t   key_new;
	logic   self_pair;
	logic   full;
	cnt_t   k_next;
	logic   dup;
	logic   scan_wr;
	logic   at_end;

	logic   we;
	addr_t  waddr, raddr;
	key_t   wdata, rdata;

	opsd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_PAIRS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign id_a      = id_t'(in_first);
	assign id_b      = id_t'(in_second);
	assign self_pair = (id_a == id_b);
	assign key_new   = (id_a < id_b) ? {id_a, id_b} : {id_b, id_a};
	assign full      = (cnt_q == cnt_t'(MAX_PAIRS));
	assign k_next    = cnt_t'(k_q) + cnt_t'(1);
	assign dup       = !ins_q && (rdata == key_q);
	assign scan_wr   = ins_q || (rdata > key_q);
	assign at_end    = (k_next == ucnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_kind == KIND_ADD) begin
						if (!self_pair && !full) begin
							state_d = (ucnt_q == '0) ? ST_TAIL : ST_SCAN;
						end
					end else begin
						state_d = (cnt_q == '0) ? ST_FEMPTY : ST_FRD;
					end
				end
			end
			ST_SCAN: begin
				if (dup) begin
					state_d = ST_IDLE;
				end else if (at_end) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_IDLE;
			end
			ST_FRD: begin
				state_d = ST_FOUT;
			end
			ST_FOUT: begin
				if (out_free) begin
					state_d = at_end ? ST_IDLE : ST_FRD;
				end
			end
			ST_FEMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// RAM access and result load
	always_comb begin
		we      = 1'b0;
		waddr   = k_q;
		wdata   = ins_q ? carry_q : key_q;
		raddr   = '0;
		out_req = '0;
		case (state_q)
			ST_IDLE: begin
				raddr = '0;
			end
			ST_SCAN: begin
				raddr = addr_t'(k_next);
				we    = scan_wr;
			end
			ST_TAIL: begin
				we    = 1'b1;
				waddr = addr_t'(ucnt_q);
			end
			ST_FRD: begin
				raddr = k_q;
			end
			ST_FOUT: begin
				raddr                  = k_q;
				out_req.load           = out_free;
				out_req.res.pair_low   = ID_W'(rdata[KEY_W-1:ID_BITS]);
				out_req.res.pair_high  = ID_W'(rdata[ID_BITS-1:0]);
				out_req.res.is_empty   = 1'b0;
				out_req.res.overflowed = ovf_q;
				out_req.res.last       = at_end;
			end
			ST_FEMPTY: begin
				out_req.load           = out_free;
				out_req.res.is_empty   = 1'b1;
				out_req.res.overflowed = ovf_q;
				out_req.res.last       = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ucnt_q  <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					k_q   <= '0;
					ins_q <= 1'b0;
					if (acc && (in_kind == KIND_ADD) && !self_pair) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + cnt_t'(1);
						end
					end
				end
				ST_SCAN: begin
					k_q <= addr_t'(k_next);
					if (scan_wr) begin
						ins_q <= 1'b1;
					end
				end
				ST_TAIL: begin
					ucnt_q <= ucnt_q + cnt_t'(1);
				end
				ST_FOUT: begin
					if (out_free) begin
						if (at_end) begin
							cnt_q  <= '0;
							ucnt_q <= '0;
							ovf_q  <= 1'b0;
						end else begin
							k_q <= addr_t'(k_next);
						end
					end
				end
				ST_FEMPTY: begin
					if (out_free) begin
						ovf_q <= 1'b0;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= key_new;
		end
		if ((state_q == ST_SCAN) && scan_wr) begin
			carry_q <= rdata;
		end
	end

endmodule

FILE: sv/opsd_outreg.sv
// ---------------------------------------------------------------------------
// opsd_outreg
// Output register of the result stream.
// ---------------------------------------------------------------------------
module opsd_outreg (
	input  logic               clk,
	input  logic               arst_n,
	input  opsd_pkg::out_req_t req,
	output logic               free,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);
	import opsd_pkg::*;

	logic vld_q;
	res_t res_q;

	assign free = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= req.load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && req.load) begin
			res_q <= req.res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {res_q.pair_high, res_q.pair_low};
	assign m_tuser  = {res_q.overflowed, res_q.is_empty};
	assign m_tlast  = res_q.last;

endmodule

FILE: sv/overlap_pair_sort_dedup.sv
// ---------------------------------------------------------------------------
// overlap_pair_sort_dedup
// Collects overlap pairs of node ids; on finish emits each distinct pair once,
// sorted by lower id then higher id.
//
// Input stream: one word per add or finish. An add orders the pair and
// inserts it into a sorted RAM list, skipping self pairs and duplicates.
// An add walks the list from the bottom in a RAM read-compare-write loop, one
// stored distinct pair per step. When 64 non-self adds have been taken,
// duplicates included, further adds are dropped and the overflow flag is set.
// A finish reads the list out in order, each result word by a RAM read and then
// a load of the output register; the last word carries tlast. With
// no pairs, one word with the empty flag and tlast is sent. Afterwards the
// store and the flag are cleared.
// Input is taken only between operations. A stalled receiver holds the
// output register and pauses the readout; no word is lost.
// Reset empties the store and clears the overflow flag; no clearing pass.
// ---------------------------------------------------------------------------
module overlap_pair_sort_dedup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // first_id[15:0], second_id[31:16]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // pair_low[15:0], pair_high[31:16]
	output logic [1:0]  m_tuser,  // is_empty[0], overflowed[1]
	output logic        m_tlast
);
	import opsd_pkg::*;

	out_req_t req;
	logic     free;

	opsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser[0]),
		.in_first  (s_tdata[15:0]),
		.in_second (s_tdata[31:16]),
		.out_free  (free),
		.out_req   (req)
	);

	opsd_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: sv/opsd_checker.sv
// ---------------------------------------------------------------------------
// opsd_checker
// Port-level checks of the overlap pair sort and dedup block.
// ---------------------------------------------------------------------------
`include "overlap_pair_sort_dedup_macros.svh"

module opsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	`OPSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
	`OPSD_ASSERT_IMPL(a_empty_last, m_tvalid && m_tuser[0], m_tlast)
	`OPSD_ASSERT_IMPL(a_empty_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0)
	`OPSD_ASSERT_IMPL(a_run_busy, m_tvalid && !m_tlast, !s_tready)

endmodule

bind overlap_pair_sort_dedup opsd_checker u_opsd_checker (.*);
